@@ sv/ipv4_tunnel_packet_filter_macros.svh @@
// Assertion macros used by the checker file of the IPv4 tunnel packet filter.
`ifndef IPV4_TUNNEL_PACKET_FILTER_MACROS_SVH
`define IPV4_TUNNEL_PACKET_FILTER_MACROS_SVH

// Plain property check, clocked on the rising edge and off during reset.
`define IPV4TF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Overlapping implication: the consequent holds in the same cycle as the antecedent.
`define IPV4TF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: the consequent holds in the cycle after the antecedent.
`define IPV4TF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ipv4tf_pkg.sv @@
// Package with the types, codes and constants of the IPv4 tunnel packet filter.
`timescale 1ns / 1ps
`default_nettype none

package ipv4tf_pkg;

    // Port-list size and configuration port geometry.
    localparam int DEFAULT_ALLOWED_PORTS = 4;
    localparam int MAX_ALLOWED_PORTS     = 4;
    localparam int CFG_INDEX_W           = 3;
    localparam int CFG_DATA_W            = 32;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_DST   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_SRC   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PORT_LIST_LEN  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALLOWED_PORT_0 = 3'd3;

    // Verdict codes.
    localparam logic [2:0] VERDICT_ALLOW            = 3'd0;
    localparam logic [2:0] VERDICT_NOT_IPV4         = 3'd1;
    localparam logic [2:0] VERDICT_WRONG_DST        = 3'd2;
    localparam logic [2:0] VERDICT_WRONG_SRC        = 3'd3;
    localparam logic [2:0] VERDICT_PORT_NOT_ALLOWED = 3'd4;

    // Header byte offsets of the captured fields.
    localparam logic [15:0] OFS_VER_IHL = 16'd0;
    localparam logic [15:0] OFS_FRAG_HI = 16'd6;
    localparam logic [15:0] OFS_FRAG_LO = 16'd7;
    localparam logic [15:0] OFS_PROTO   = 16'd9;
    localparam logic [15:0] OFS_SRC     = 16'd12;
    localparam logic [15:0] OFS_DST     = 16'd16;

    // Header checks.
    localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
    localparam logic [3:0]  IP_VERSION_4     = 4'd4;
    localparam logic [7:0]  PROTO_TCP        = 8'd6;
    localparam logic [7:0]  PROTO_UDP        = 8'd17;
    localparam logic [31:0] MCAST_MASK       = 32'hf000_0000;
    localparam logic [31:0] MCAST_PREFIX     = 32'he000_0000;
    localparam logic [15:0] BYTE_COUNT_MAX   = 16'hffff;

    // One input transaction.
    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } pkt_t;

    // One result transaction.
    typedef struct packed {
        logic [2:0]  verdict;
        logic [7:0]  protocol_number;
        logic        port_present;
        logic [15:0] destination_port;
    } res_t;

    // Filter settings other than the port list.
    typedef struct packed {
        logic [31:0] expected_destination;
        logic [31:0] expected_source;
        logic [2:0]  port_list_length;
    } cfg_t;

    // Header fields of a finished packet, handed from capture to verdict.
    typedef struct packed {
        logic [15:0] size;
        logic [7:0]  version_ihl;
        logic [12:0] fragment;
        logic [7:0]  protocol;
        logic [31:0] source;
        logic [31:0] destination;
        logic [15:0] port_bytes;
        logic [1:0]  port_bytes_seen;
    } hdr_t;

endpackage

`default_nettype wire

@@ sv/ipv4tf_cfg_regs.sv @@
// Configuration registers of the IPv4 tunnel packet filter.
`timescale 1ns / 1ps
`default_nettype none

module ipv4tf_cfg_regs #(
    parameter int ALLOWED_PORTS = ipv4tf_pkg::DEFAULT_ALLOWED_PORTS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ipv4tf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ipv4tf_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ipv4tf_pkg::cfg_t                        cfg,
    output logic [15:0]                             ports [ALLOWED_PORTS]
);

    logic             cfg_wr;
    ipv4tf_pkg::cfg_t cfg_reg;
    ipv4tf_pkg::cfg_t cfg_next;
    logic [15:0]      ports_reg  [ALLOWED_PORTS];
    logic [15:0]      ports_next [ALLOWED_PORTS];

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Decode the register index; indexes past the list are dropped.
    always_comb
    begin
        cfg_next   = cfg_reg;
        ports_next = ports_reg;
        if (cfg_wr)
        begin
            if (cfg_index == ipv4tf_pkg::CFG_EXPECTED_DST)
            begin
                cfg_next.expected_destination = cfg_data[31:0];
            end
            if (cfg_index == ipv4tf_pkg::CFG_EXPECTED_SRC)
            begin
                cfg_next.expected_source = cfg_data[31:0];
            end
            if (cfg_index == ipv4tf_pkg::CFG_PORT_LIST_LEN)
            begin
                cfg_next.port_list_length = cfg_data[2:0];
            end
            for (int k = 0; k < ALLOWED_PORTS; k++)
            begin
                if (cfg_index == ipv4tf_pkg::CFG_ALLOWED_PORT_0 + ipv4tf_pkg::CFG_INDEX_W'(k))
                begin
                    ports_next[k] = cfg_data[15:0];
                end
            end
        end
    end

    // Settings reset to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
            for (int k = 0; k < ALLOWED_PORTS; k++)
            begin
                ports_reg[k] <= 16'd0;
            end
        end
        else
        begin
            cfg_reg   <= cfg_next;
            ports_reg <= ports_next;
        end
    end

    assign cfg   = cfg_reg;
    assign ports = ports_reg;

endmodule

`default_nettype wire

@@ sv/ipv4tf_capture.sv @@
// Byte counter and header field capture of the IPv4 tunnel packet filter.
`timescale 1ns / 1ps
`default_nettype none

module ipv4tf_capture (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    pkt_valid,
    output logic                         pkt_stall,
    input  wire ipv4tf_pkg::pkt_t        pkt,
    input  wire logic                    hdr_take,
    output logic                         hdr_valid,
    output ipv4tf_pkg::hdr_t             hdr
);

    logic             accept;
    logic [15:0]      byte_count_reg;
    logic [15:0]      byte_count_next;
    logic [15:0]      byte_count_inc;
    logic [7:0]       vihl_reg;
    logic [7:0]       vihl_next;
    logic [12:0]      frag_reg;
    logic [12:0]      frag_next;
    logic [7:0]       proto_reg;
    logic [7:0]       proto_next;
    logic [31:0]      src_reg;
    logic [31:0]      src_next;
    logic [31:0]      dst_reg;
    logic [31:0]      dst_next;
    logic [15:0]      port_reg;
    logic [15:0]      port_next;
    logic [1:0]       seen_reg;
    logic [1:0]       seen_next;
    logic [3:0]       ihl_words;
    logic [15:0]      port_hi_idx;
    logic [15:0]      port_lo_idx;
    logic [7:0]       b;
    ipv4tf_pkg::hdr_t hdr_reg;
    ipv4tf_pkg::hdr_t hdr_next;
    logic             hdr_valid_reg;
    logic             hdr_valid_next;

    // A finished header that cannot move on blocks the byte stream.
    assign pkt_stall = hdr_valid_reg && !hdr_take;
    assign accept    = pkt_valid && !pkt_stall;
    assign b         = pkt.packet_byte;

    // Port byte positions follow the header length, taken from this byte at offset zero.
    always_comb
    begin
        ihl_words   = (byte_count_reg == ipv4tf_pkg::OFS_VER_IHL) ? b[3:0] : vihl_reg[3:0];
        port_hi_idx = {10'd0, ihl_words, 2'b00} + 16'd2;
        port_lo_idx = {10'd0, ihl_words, 2'b00} + 16'd3;
    end

    // Field capture for the byte at the current offset.
    always_comb
    begin
        vihl_next  = vihl_reg;
        frag_next  = frag_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        port_next  = port_reg;
        seen_next  = seen_reg;

        if (byte_count_reg == ipv4tf_pkg::OFS_VER_IHL)
        begin
            vihl_next = b;
        end
        if (byte_count_reg == ipv4tf_pkg::OFS_FRAG_HI)
        begin
            frag_next = {b[4:0], 8'd0};
        end
        if (byte_count_reg == ipv4tf_pkg::OFS_FRAG_LO)
        begin
            frag_next[7:0] = b;
        end
        if (byte_count_reg == ipv4tf_pkg::OFS_PROTO)
        begin
            proto_next = b;
        end
        if (byte_count_reg >= ipv4tf_pkg::OFS_SRC && byte_count_reg < ipv4tf_pkg::OFS_DST)
        begin
            src_next = {src_reg[23:0], b};
        end
        if (byte_count_reg >= ipv4tf_pkg::OFS_DST && byte_count_reg < ipv4tf_pkg::MIN_HEADER_BYTES)
        begin
            dst_next = {dst_reg[23:0], b};
        end

        priority if (byte_count_reg == port_hi_idx)
        begin
            port_next = {b, 8'd0};
            seen_next = 2'd1;
        end
        else if (byte_count_reg == port_lo_idx && seen_reg == 2'd1)
        begin
            port_next[7:0] = b;
            seen_next      = 2'd2;
        end
        else
        begin
            port_next = port_reg;
        end

        byte_count_inc = (byte_count_reg != ipv4tf_pkg::BYTE_COUNT_MAX) ?
                         byte_count_reg + 16'd1 : byte_count_reg;
    end

    // On the last byte the packet is handed on and the capture state cleared.
    always_comb
    begin
        hdr_next.size            = byte_count_inc;
        hdr_next.version_ihl     = vihl_next;
        hdr_next.fragment        = frag_next;
        hdr_next.protocol        = proto_next;
        hdr_next.source          = src_next;
        hdr_next.destination     = dst_next;
        hdr_next.port_bytes      = port_next;
        hdr_next.port_bytes_seen = seen_next;
        byte_count_next          = byte_count_inc;
        hdr_valid_next           = hdr_valid_reg && !hdr_take;
        if (accept && pkt.last_byte)
        begin
            hdr_valid_next  = 1'b1;
            byte_count_next = 16'd0;
        end
    end

    // Capture state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= 16'd0;
            vihl_reg       <= 8'd0;
            frag_reg       <= 13'd0;
            proto_reg      <= 8'd0;
            src_reg        <= 32'd0;
            dst_reg        <= 32'd0;
            port_reg       <= 16'd0;
            seen_reg       <= 2'd0;
            hdr_valid_reg  <= 1'b0;
        end
        else
        begin
            hdr_valid_reg <= hdr_valid_next;
            if (accept)
            begin
                byte_count_reg <= byte_count_next;
                if (pkt.last_byte)
                begin
                    vihl_reg  <= 8'd0;
                    frag_reg  <= 13'd0;
                    proto_reg <= 8'd0;
                    src_reg   <= 32'd0;
                    dst_reg   <= 32'd0;
                    port_reg  <= 16'd0;
                    seen_reg  <= 2'd0;
                end
                else
                begin
                    vihl_reg  <= vihl_next;
                    frag_reg  <= frag_next;
                    proto_reg <= proto_next;
                    src_reg   <= src_next;
                    dst_reg   <= dst_next;
                    port_reg  <= port_next;
                    seen_reg  <= seen_next;
                end
            end
        end
    end

    // Finished header register.
    always_ff @(posedge clk)
    begin
        if (accept && pkt.last_byte)
        begin
            hdr_reg <= hdr_next;
        end
    end

    assign hdr_valid = hdr_valid_reg;
    assign hdr       = hdr_reg;

endmodule

`default_nettype wire

@@ sv/ipv4tf_verdict.sv @@
// Verdict logic and result register of the IPv4 tunnel packet filter.
`timescale 1ns / 1ps
`default_nettype none

module ipv4tf_verdict #(
    parameter int ALLOWED_PORTS = ipv4tf_pkg::DEFAULT_ALLOWED_PORTS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ipv4tf_pkg::cfg_t  cfg,
    input  wire logic [15:0]       ports [ALLOWED_PORTS],
    input  wire logic              hdr_valid,
    input  wire ipv4tf_pkg::hdr_t  hdr,
    output logic                   hdr_take,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output ipv4tf_pkg::res_t       res
);

    logic             res_valid_reg;
    logic             res_valid_next;
    ipv4tf_pkg::res_t res_reg;
    ipv4tf_pkg::res_t res_next;
    logic [5:0]       ihl_bytes;
    logic             header_ok;
    logic             port_ok;
    logic             multicast;
    logic             src_match;
    logic             dst_match;
    logic [2:0]       list_len;
    logic             port_hit;

    // The result register takes a new verdict when empty or when its transaction completes.
    assign hdr_take = hdr_valid && (!res_valid_reg || !res_stall);

    // Header sanity and address checks.
    always_comb
    begin
        ihl_bytes = {hdr.version_ihl[3:0], 2'b00};
        header_ok = (hdr.size >= ipv4tf_pkg::MIN_HEADER_BYTES)
                 && (hdr.version_ihl[7:4] == ipv4tf_pkg::IP_VERSION_4)
                 && ({10'd0, ihl_bytes} >= ipv4tf_pkg::MIN_HEADER_BYTES)
                 && ({10'd0, ihl_bytes} <= hdr.size);
        port_ok   = (hdr.protocol == ipv4tf_pkg::PROTO_TCP || hdr.protocol == ipv4tf_pkg::PROTO_UDP)
                 && (hdr.fragment == 13'd0)
                 && (hdr.port_bytes_seen == 2'd2);
        multicast = (hdr.destination & ipv4tf_pkg::MCAST_MASK) == ipv4tf_pkg::MCAST_PREFIX;
        src_match = hdr.source == cfg.expected_source;
        dst_match = hdr.destination == cfg.expected_destination;
    end

    // Allow-list lookup over the ports in use.
    always_comb
    begin
        list_len = (cfg.port_list_length > 3'(ALLOWED_PORTS)) ?
                   3'(ALLOWED_PORTS) : cfg.port_list_length;
        port_hit = 1'b0;
        for (int k = 0; k < ALLOWED_PORTS; k++)
        begin
            if (3'(k) < list_len && ports[k] == hdr.port_bytes)
            begin
                port_hit = 1'b1;
            end
        end
    end

    // Verdict in order of precedence.
    always_comb
    begin
        res_next.protocol_number  = header_ok ? hdr.protocol : 8'd0;
        res_next.port_present     = header_ok && port_ok;
        res_next.destination_port = (header_ok && port_ok) ? hdr.port_bytes : 16'd0;
        priority if (!header_ok)
        begin
            res_next.verdict = ipv4tf_pkg::VERDICT_NOT_IPV4;
        end
        else if (multicast)
        begin
            res_next.verdict = src_match ? ipv4tf_pkg::VERDICT_ALLOW
                                         : ipv4tf_pkg::VERDICT_WRONG_SRC;
        end
        else if (!dst_match)
        begin
            res_next.verdict = ipv4tf_pkg::VERDICT_WRONG_DST;
        end
        else if (!src_match)
        begin
            res_next.verdict = ipv4tf_pkg::VERDICT_WRONG_SRC;
        end
        else if (list_len == 3'd0 || (port_ok && port_hit))
        begin
            res_next.verdict = ipv4tf_pkg::VERDICT_ALLOW;
        end
        else
        begin
            res_next.verdict = ipv4tf_pkg::VERDICT_PORT_NOT_ALLOWED;
        end
    end

    // Result valid flag.
    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        if (hdr_take)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (hdr_take)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

@@ sv/ipv4_tunnel_packet_filter.sv @@
// IPv4 tunnel packet filter: one verdict per packet from a byte stream.
//
// The packet enters on pkt, one byte per transaction in wire order, with last_byte set
// on its final byte; pkt_valid and pkt_stall hand it over. For each packet one result
// transaction leaves on res (verdict, protocol, port flag and destination port) under
// res_valid and res_stall. Bytes without the last mark give no result.
// Settings are written on the cfg port by index (valid/ready, always ready); the user
// must write them only while no packet is in flight, which the block does not enforce.
// Indexes past the port list are ignored. Throughput is one byte per cycle while
// pkt_stall is low, set by the single capture stage. A result reaches res after its last
// byte is taken, once the finished-header register has passed it to the result register.
// Reset clears all settings to zero and starts a new packet at byte zero.
// While res is stalled the result is held; one further finished packet waits in the
// header register, and pkt_stall rises only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_tunnel_packet_filter #(
    parameter int ALLOWED_PORTS = ipv4tf_pkg::DEFAULT_ALLOWED_PORTS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               pkt_valid,
    output logic                                    pkt_stall,
    input  wire ipv4tf_pkg::pkt_t                   pkt,
    output logic                                    res_valid,
    input  wire logic                               res_stall,
    output ipv4tf_pkg::res_t                        res,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ipv4tf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ipv4tf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    ipv4tf_pkg::cfg_t cfg;
    logic [15:0]      ports [ALLOWED_PORTS];
    logic             hdr_valid;
    logic             hdr_take;
    ipv4tf_pkg::hdr_t hdr;

    // Settings.
    ipv4tf_cfg_regs #(
        .ALLOWED_PORTS (ALLOWED_PORTS)
    ) u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .ports     (ports)
    );

    // Byte stream to finished header.
    ipv4tf_capture u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt       (pkt),
        .hdr_take  (hdr_take),
        .hdr_valid (hdr_valid),
        .hdr       (hdr)
    );

    // Finished header to result.
    ipv4tf_verdict #(
        .ALLOWED_PORTS (ALLOWED_PORTS)
    ) u_verdict (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .ports     (ports),
        .hdr_valid (hdr_valid),
        .hdr       (hdr),
        .hdr_take  (hdr_take),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

`default_nettype wire

@@ sv/ipv4tf_checker.sv @@
// Port-level assertion checker for the IPv4 tunnel packet filter, with its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "ipv4_tunnel_packet_filter_macros.svh"

module ipv4tf_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               pkt_stall,
    input wire logic                               res_valid,
    input wire logic                               res_stall,
    input wire ipv4tf_pkg::res_t                   res
);

    // A stalled result transaction stays put.
    `IPV4TF_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid && $stable(res), "result changed while stalled")

    // Only defined verdict codes leave the block.
    `IPV4TF_ASSERT_IMPLY(a_verdict_range, clk, rst_n, res_valid, res.verdict <= ipv4tf_pkg::VERDICT_PORT_NOT_ALLOWED, "undefined verdict code")

    // A packet that is not IPv4 carries no protocol and no port.
    `IPV4TF_ASSERT_IMPLY(a_not_ipv4_zero, clk, rst_n, res_valid && res.verdict == ipv4tf_pkg::VERDICT_NOT_IPV4, res.protocol_number == 8'd0 && !res.port_present && res.destination_port == 16'd0, "not_ipv4 result with fields set")

    // The byte stream is held back only behind a stalled result.
    `IPV4TF_ASSERT_IMPLY(a_stall_cause, clk, rst_n, pkt_stall, res_valid && res_stall, "input stalled without a stalled result")

endmodule

bind ipv4_tunnel_packet_filter ipv4tf_checker u_checker (.*);

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the IPv4 tunnel packet filter: directed and random packets.
`timescale 1ns / 1ps

module testbench;
    import ipv4tf_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
    localparam int PORT_SLOTS = DEFAULT_ALLOWED_PORTS;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PACKETS = 2;
    localparam logic [7:0] V4_IHL5 = {IP_VERSION_4, 4'd5};

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pkt_valid = 1'b0;
    logic pkt_stall;
    pkt_t pkt = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Copy of the filter settings, kept in step with every accepted register write.
    logic [31:0] cfg_dst = '0;
    logic [31:0] cfg_src = '0;
    logic [2:0] cfg_list_len = '0;
    logic [15:0] cfg_ports [PORT_SLOTS] = '{default: '0};

    // Header fields of the packet in progress, as the filter should capture them.
    logic [15:0] byte_total = '0;
    logic [7:0] ver_ihl_cap = '0;
    logic [12:0] frag_cap = '0;
    logic [7:0] proto_cap = '0;
    logic [31:0] src_cap = '0;
    logic [31:0] dst_cap = '0;
    logic [15:0] port_cap = '0;
    logic [1:0] port_got = '0;

    pkt_t pending_bytes[$];
    res_t verdicts_due[$];
    logic [7:0] octets[$];
    int error_count = 0;

    int burst_left = 0;
    int gap_left = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int stall_run = 0;

    ipv4_tunnel_packet_filter uut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Print one mismatch line and count it.
    task automatic report_error(input string what, input int got, input int want);
        $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Follow one accepted byte through the header capture; on the last byte work out
    // the verdict and queue it.
    task automatic track_packet_byte(input pkt_t item);
        int idx;
        int ihl;
        int size;
        int n;
        logic ok;
        res_t want;
        idx = int'(byte_total);
        ihl = 4 * int'((idx == 0) ? item.packet_byte[3:0] : ver_ihl_cap[3:0]);
        if (idx == OFS_VER_IHL)
            ver_ihl_cap = item.packet_byte;
        if (idx == OFS_FRAG_HI)
            frag_cap = {item.packet_byte[4:0], 8'h00};
        if (idx == OFS_FRAG_LO)
            frag_cap[7:0] = item.packet_byte;
        if (idx == OFS_PROTO)
            proto_cap = item.packet_byte;
        if (idx >= OFS_SRC && idx < OFS_SRC + 4)
            src_cap = {src_cap[23:0], item.packet_byte};
        if (idx >= OFS_DST && idx < OFS_DST + 4)
            dst_cap = {dst_cap[23:0], item.packet_byte};

        // Destination port bytes sit just past the header, after the source port.
        if (idx == ihl + 2)
        begin
            port_cap = {item.packet_byte, 8'h00};
            port_got = 2'd1;
        end
        else if (idx == ihl + 3 && port_got == 2'd1)
        begin
            port_cap[7:0] = item.packet_byte;
            port_got = 2'd2;
        end
        if (byte_total != BYTE_COUNT_MAX)
            byte_total++;

        if (item.last_byte)
        begin
            size = int'(byte_total);
            ihl = 4 * int'(ver_ihl_cap[3:0]);
            ok = size >= MIN_HEADER_BYTES && ver_ihl_cap[7:4] == IP_VERSION_4
                && ihl >= MIN_HEADER_BYTES && ihl <= size;
            want = '0;
            if (!ok)
                want.verdict = VERDICT_NOT_IPV4;
            else
            begin
                want.protocol_number = proto_cap;
                if ((proto_cap == PROTO_TCP || proto_cap == PROTO_UDP) && frag_cap == '0
                    && port_got == 2'd2)
                begin
                    want.port_present = 1'b1;
                    want.destination_port = port_cap;
                end
                n = (int'(cfg_list_len) > PORT_SLOTS) ? PORT_SLOTS : int'(cfg_list_len);
                if ((dst_cap & MCAST_MASK) == MCAST_PREFIX)
                    want.verdict = (src_cap == cfg_src) ? VERDICT_ALLOW : VERDICT_WRONG_SRC;
                else if (dst_cap != cfg_dst)
                    want.verdict = VERDICT_WRONG_DST;
                else if (src_cap != cfg_src)
                    want.verdict = VERDICT_WRONG_SRC;
                else if (n == 0)
                    want.verdict = VERDICT_ALLOW;
                else
                begin
                    want.verdict = VERDICT_PORT_NOT_ALLOWED;
                    for (int k = 0; k < n; k++)
                        if (want.port_present && cfg_ports[k] == port_cap)
                            want.verdict = VERDICT_ALLOW;
                end
            end
            verdicts_due.push_back(want);

            // Every packet starts from a clean capture.
            byte_total = '0;
            ver_ihl_cap = '0;
            frag_cap = '0;
            proto_cap = '0;
            src_cap = '0;
            dst_cap = '0;
            port_cap = '0;
            port_got = '0;
        end
    endtask

    // Compare one result transaction with the oldest verdict still due.
    task automatic check_result(input res_t got);
        res_t want;
        if (verdicts_due.size() == 0)
            report_error("result with no packet pending, verdict", got.verdict, -1);
        else
        begin
            want = verdicts_due.pop_front();
            if (got.verdict != want.verdict)
                report_error("verdict", got.verdict, want.verdict);
            if (got.protocol_number != want.protocol_number)
                report_error("protocol_number", got.protocol_number, want.protocol_number);
            if (got.port_present != want.port_present)
                report_error("port_present", got.port_present, want.port_present);
            if (got.destination_port != want.destination_port)
                report_error("destination_port", got.destination_port, want.destination_port);
        end
    endtask

    // Packet byte driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_valid <= 1'b0;
            pkt <= '0;
        end
        else
        begin
            if (pkt_valid && !pkt_stall)
                track_packet_byte(pkt);
            if (!(pkt_valid && pkt_stall))
            begin
                if (gap_left > 0 || pending_bytes.size() == 0)
                begin
                    pkt_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    pkt <= pending_bytes.pop_front();
                    pkt_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(4, 48);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Result monitor; the stall pattern switches between a few modes every so often.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
        begin
            if (res_valid && !res_stall)
                check_result(res);
            if (stall_run == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                stall_run = $urandom_range(20, 120);
            end
            else
                stall_run--;
            case (stall_mode)
                STALL_NONE: res_stall <= 1'b0;
                STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
                default: res_stall <= ~res_stall;
            endcase
        end
    end

    // One register write transaction; the settings copy follows on acceptance.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == CFG_EXPECTED_DST)
            cfg_dst = value;
        else if (index == CFG_EXPECTED_SRC)
            cfg_src = value;
        else if (index == CFG_PORT_LIST_LEN)
            cfg_list_len = value[2:0];
        else if (index >= CFG_ALLOWED_PORT_0 && index < CFG_ALLOWED_PORT_0 + PORT_SLOTS)
            cfg_ports[index - CFG_ALLOWED_PORT_0] = value[15:0];
    endtask

    // Write every register, plus the unused index, which must change nothing.
    task automatic apply_settings(input logic [31:0] dst, input logic [31:0] src,
                                  input logic [31:0] len_word, input logic [15:0] p0,
                                  input logic [15:0] p1, input logic [15:0] p2,
                                  input logic [15:0] p3);
        write_register(CFG_EXPECTED_DST, dst);
        write_register(CFG_EXPECTED_SRC, src);
        write_register(CFG_PORT_LIST_LEN, len_word);
        write_register(CFG_ALLOWED_PORT_0, {16'($urandom), p0});
        write_register(CFG_ALLOWED_PORT_0 + 3'd1, {16'($urandom), p1});
        write_register(CFG_ALLOWED_PORT_0 + 3'd2, {16'($urandom), p2});
        write_register(CFG_ALLOWED_PORT_0 + 3'd3, {16'($urandom), p3});
        write_register(CFG_UNUSED_INDEX, $urandom);
    endtask

    // Wait until every byte is taken and every verdict has come back, then settle.
    task automatic drain;
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || pkt_valid || verdicts_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_octet(input int index, input logic [7:0] value);
        if (index < octets.size())
            octets[index] = value;
    endtask

    // Build a packet of random bytes with the given header fields laid over it.
    task automatic make_packet(input logic [7:0] ver_ihl, input logic [12:0] frag,
                               input logic [7:0] proto, input logic [31:0] src,
                               input logic [31:0] dst, input logic [15:0] port,
                               input int length);
        int ofs;
        octets.delete();
        for (int i = 0; i < length; i++)
            octets.push_back(8'($urandom));
        ofs = 4 * int'(ver_ihl[3:0]);
        put_octet(OFS_VER_IHL, ver_ihl);
        put_octet(OFS_FRAG_HI, {3'($urandom), frag[12:8]});
        put_octet(OFS_FRAG_LO, frag[7:0]);
        put_octet(OFS_PROTO, proto);
        for (int k = 0; k < 4; k++)
        begin
            put_octet(OFS_SRC + k, src[31 - 8 * k -: 8]);
            put_octet(OFS_DST + k, dst[31 - 8 * k -: 8]);
        end
        put_octet(ofs + 2, port[15:8]);
        put_octet(ofs + 3, port[7:0]);
    endtask

    // Hand the built packet to the driver, marking its final byte.
    task automatic post_packet;
        pkt_t item;
        for (int i = 0; i < octets.size(); i++)
        begin
            item.packet_byte = octets[i];
            item.last_byte = (i == octets.size() - 1);
            pending_bytes.push_back(item);
        end
    endtask

    // Mostly well-formed packets aimed at the current settings, some broken ones and noise.
    task automatic queue_random_packet;
        int ihl;
        int length;
        logic [7:0] ver_ihl;
        logic [12:0] frag;
        logic [7:0] proto;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] port;
        if ($urandom_range(0, 19) == 0)
        begin
            octets.delete();
            repeat ($urandom_range(1, 40)) octets.push_back(8'($urandom));
        end
        else
        begin
            ihl = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : 5;
            ver_ihl = {(($urandom_range(0, 9) == 0) ? 4'($urandom) : IP_VERSION_4), 4'(ihl)};
            case ($urandom_range(0, 9))
                0: length = $urandom_range(1, 19);
                1: length = $urandom_range(1, 4 * ihl + 3);
                default: length = 4 * ihl + 4 + $urandom_range(0, 12);
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: dst = cfg_dst;
                5, 6: dst = {4'he, 28'($urandom)};
                7: dst = cfg_dst ^ (32'd1 << $urandom_range(0, 31));
                default: dst = $urandom;
            endcase
            case ($urandom_range(0, 9))
                7: src = cfg_src ^ (32'd1 << $urandom_range(0, 31));
                8, 9: src = $urandom;
                default: src = cfg_src;
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3: proto = PROTO_TCP;
                4, 5, 6, 7: proto = PROTO_UDP;
                default: proto = 8'($urandom);
            endcase
            frag = ($urandom_range(0, 7) == 0) ? 13'($urandom) : '0;
            port = ($urandom_range(0, 2) != 0) ? cfg_ports[$urandom_range(0, PORT_SLOTS - 1)]
                                               : 16'($urandom);
            make_packet(ver_ihl, frag, proto, src, dst, port, length);
        end
        post_packet();
    endtask

    // Main sequence: reset, then phases of packets under different settings.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings expect all-zero addresses and no port list.
        make_packet(V4_IHL5, '0, PROTO_UDP, '0, '0, 16'd53, 28);
        post_packet();
        drain();

        // Directed packets against a two-entry port list.
        apply_settings(32'hc0a8_0101, 32'h0a00_0001, 32'd2, 16'd4789, 16'd443, 16'd8080,
                       16'd22);
        make_packet(V4_IHL5, '0, PROTO_UDP, cfg_src, cfg_dst, 16'd4789, 24);
        post_packet();
        make_packet(V4_IHL5, '0, PROTO_TCP, cfg_src, cfg_dst, 16'd443, 29);
        post_packet();
        // A port past the end of the list in use is not allowed.
        make_packet(V4_IHL5, '0, PROTO_UDP, cfg_src, cfg_dst, 16'd8080, 24);
        post_packet();
        // Too short, wrong version, header length too small or longer than the packet.
        make_packet(V4_IHL5, '0, PROTO_UDP, cfg_src, cfg_dst, 16'd4789, 19);
        post_packet();
        octets.delete();
        octets.push_back(V4_IHL5);
        post_packet();
        make_packet({4'd6, 4'd5}, '0, PROTO_UDP, cfg_src, cfg_dst, 16'd4789, 24);
        post_packet();
        make_packet({IP_VERSION_4, 4'd4}, '0, PROTO_UDP, cfg_src, cfg_dst, 16'd4789, 24);
        post_packet();
        make_packet({IP_VERSION_4, 4'd15}, '0, PROTO_UDP, cfg_src, cfg_dst, 16'd4789, 40);
        post_packet();
        // Longest header, port bytes at the very end.
        make_packet({IP_VERSION_4, 4'd15}, '0, PROTO_UDP, cfg_src, cfg_dst, 16'd4789, 64);
        post_packet();
        // Address mismatches, and multicast checked against the source only.
        make_packet(V4_IHL5, '0, PROTO_UDP, cfg_src, cfg_dst ^ 32'd1, 16'd4789, 24);
        post_packet();
        make_packet(V4_IHL5, '0, PROTO_UDP, cfg_src ^ 32'h8000_0000, cfg_dst, 16'd4789, 24);
        post_packet();
        make_packet(V4_IHL5, '0, PROTO_UDP, cfg_src, 32'he000_0000, 16'd9999, 24);
        post_packet();
        make_packet(V4_IHL5, '0, PROTO_TCP, 32'hffff_ffff, 32'hefff_ffff, 16'd443, 24);
        post_packet();
        make_packet(V4_IHL5, '0, PROTO_UDP, cfg_src, 32'hf000_0000, 16'd4789, 24);
        post_packet();
        make_packet(V4_IHL5, '0, PROTO_UDP, cfg_src, 32'hdfff_ffff, 16'd4789, 24);
        post_packet();
        // No readable port: later fragments, other protocols, packet cut before the port.
        make_packet(V4_IHL5, 13'h1fff, PROTO_UDP, cfg_src, cfg_dst, 16'd4789, 24);
        post_packet();
        make_packet(V4_IHL5, 13'h0001, PROTO_TCP, cfg_src, cfg_dst, 16'd443, 24);
        post_packet();
        make_packet(V4_IHL5, '0, 8'd1, cfg_src, cfg_dst, 16'd4789, 24);
        post_packet();
        make_packet(V4_IHL5, '0, PROTO_UDP, cfg_src, cfg_dst, 16'd4789, 22);
        post_packet();
        make_packet(V4_IHL5, '0, PROTO_TCP, cfg_src, cfg_dst, 16'd443, 23);
        post_packet();
        make_packet(V4_IHL5, '0, 8'hff, cfg_src, cfg_dst, 16'd4789, 20);
        post_packet();
        drain();
        repeat (RANDOM_PACKETS) queue_random_packet();
        drain();

        // All-ones addresses, port check off (length field with junk above its bits).
        apply_settings(32'hffff_ffff, 32'hffff_ffff, 32'hffff_fff8, 16'hffff, 16'h0000,
                       16'hffff, 16'h0000);
        repeat (RANDOM_PACKETS) queue_random_packet();
        drain();

        // Zero addresses, list length above the number of slots.
        apply_settings('0, '0, 32'd7, 16'h0000, 16'hffff, 16'h8000, 16'h0001);
        repeat (RANDOM_PACKETS) queue_random_packet();
        drain();

        // Random addresses, single-entry list.
        apply_settings($urandom, $urandom, 32'h0000_0009, 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom));
        repeat (RANDOM_PACKETS) queue_random_packet();
        drain();

        // Full list, then a TCP packet aimed at the third entry.
        apply_settings($urandom, $urandom, 32'd4, 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom));
        make_packet(V4_IHL5, '0, PROTO_TCP, cfg_src, cfg_dst, cfg_ports[2], 28);
        post_packet();
        queue_random_packet();
        drain();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Guard against a hung run.
    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ ipv4_tunnel_packet_filter.f @@
+incdir+sv
sv/ipv4tf_pkg.sv
sv/ipv4tf_cfg_regs.sv
sv/ipv4tf_capture.sv
sv/ipv4tf_verdict.sv
sv/ipv4_tunnel_packet_filter.sv
sv/ipv4tf_checker.sv
verif/testbench.sv
